// File: hw/rtl/sym3eig_pkg.sv
// ----------------------------------------------------------------------------
// sym3eig_pkg
// Shared widths, limits, command codes and arithmetic helpers for the
// symmetric 3x3 eigenvector engine.
// ----------------------------------------------------------------------------
package sym3eig_pkg;

  localparam int MATRIX_DIM = 3;
  localparam int IN_W       = 32;
  localparam int MAT_W      = 34;
  localparam int VEC_W      = 34;
  localparam int ROT_W      = 30;
  localparam int RED_W      = 37;
  localparam int SH_W       = 3;
  localparam int HOLD_W     = 36;
  localparam int OUT_W      = 32;
  localparam int ROOT_W     = 32;
  localparam int DVD_W      = 61;
  localparam int ROT_BITS   = 28;
  localparam int VEC_BITS   = 30;
  localparam int THR_W      = 16;
  localparam int SWP_W      = 7;

  localparam logic [THR_W-1:0] THR_RESET = 16'd17;
  localparam logic [SWP_W-1:0] SWP_RESET = 7'd16;

  localparam logic signed [63:0] MAT_LIM = 64'sd8589934591;
  localparam logic signed [63:0] VEC_LIM = 64'sd4294967296;
  localparam logic signed [63:0] ROT_LIM = 64'sd268435456;
  localparam logic signed [63:0] OUT_LIM = 64'sd1073741824;

  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_HYP    = 4'd2;
  localparam logic [3:0] OP_REDUCE = 4'd3;
  localparam logic [3:0] OP_SQRT   = 4'd4;
  localparam logic [3:0] OP_DIAG   = 4'd5;
  localparam logic [3:0] OP_DIV    = 4'd6;
  localparam logic [3:0] OP_CS     = 4'd7;
  localparam logic [3:0] OP_HOLD   = 4'd8;
  localparam logic [3:0] OP_WRA    = 4'd9;
  localparam logic [3:0] OP_WRE    = 4'd10;
  localparam logic [3:0] OP_NORM   = 4'd11;
  localparam logic [3:0] OP_OUT    = 4'd12;

  localparam logic [3:0] MS_NONE  = 4'd0;
  localparam logic [3:0] MS_RED   = 4'd1;
  localparam logic [3:0] MS_AIK_C = 4'd2;
  localparam logic [3:0] MS_AJK_S = 4'd3;
  localparam logic [3:0] MS_AIK_S = 4'd4;
  localparam logic [3:0] MS_AJK_C = 4'd5;
  localparam logic [3:0] MS_EJ_C  = 4'd6;
  localparam logic [3:0] MS_EI_S  = 4'd7;
  localparam logic [3:0] MS_EI_C  = 4'd8;
  localparam logic [3:0] MS_EJ_S  = 4'd9;

  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  localparam logic [1:0] PAIR_10 = 2'd0;
  localparam logic [1:0] PAIR_20 = 2'd1;
  localparam logic [1:0] PAIR_21 = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] msrc;
    logic [1:0] accm;
    logic [1:0] pair;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] sel;
    logic       vec_mode;
  } cmd_t;

  typedef struct packed {
    logic above;
    logic red_ok;
    logic sqrt_busy;
    logic div_busy;
  } stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] x,
                                               input logic signed [63:0] lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic signed [63:0] rnd64(input logic signed [63:0] x,
                                               input int sh);
    logic [63:0] m;
    logic [63:0] r;
    m = mag64(x);
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// File: hw/rtl/sym3eig_sqrt.sv
// ----------------------------------------------------------------------------
// sym3eig_sqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sym3eig_sqrt import sym3eig_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      v    <= radicand;
      r    <= '0;
      bitv <= 64'd1 << 62;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/sym3eig_div.sv
// ----------------------------------------------------------------------------
// sym3eig_div
// Restoring divider, 32 quotient bits, one bit per cycle. The quotient must
// fit in 32 bits.
// ----------------------------------------------------------------------------
module sym3eig_div import sym3eig_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [ROOT_W-1:0] divisor,
  output logic              busy,
  output logic [31:0]       quotient
);

  logic [31:0] rem;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic [32:0] rem2;

  assign rem2 = {rem, lo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem      <= 32'(dividend[DVD_W-1:32]);
      lo       <= dividend[31:0];
      quotient <= '0;
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      if (rem2 >= {1'b0, divisor}) begin
        rem      <= 32'(rem2 - {1'b0, divisor});
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= rem2[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end
      lo  <= lo << 1;
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/sym3eig_dp.sv
// ----------------------------------------------------------------------------
// sym3eig_dp
// Datapath: matrix and eigenvector registers, shared multiplier with
// accumulator, operand reduction, square root and divider units.
// ----------------------------------------------------------------------------
module sym3eig_dp import sym3eig_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic [THR_W-1:0]        thr,
  input  logic signed [IN_W-1:0]  m00,
  input  logic signed [IN_W-1:0]  m11,
  input  logic signed [IN_W-1:0]  m22,
  input  logic signed [IN_W-1:0]  m01,
  input  logic signed [IN_W-1:0]  m02,
  input  logic signed [IN_W-1:0]  m12,
  output logic signed [OUT_W-1:0] vout [MATRIX_DIM][MATRIX_DIM]
);

  logic signed [MAT_W-1:0]  d [MATRIX_DIM];
  logic signed [MAT_W-1:0]  o [MATRIX_DIM];
  logic signed [VEC_W-1:0]  e [MATRIX_DIM][MATRIX_DIM];
  logic [RED_W-1:0]         red [MATRIX_DIM];
  logic                     neg [MATRIX_DIM];
  logic [SH_W-1:0]          sh;
  logic signed [ROT_W-1:0]  c;
  logic signed [ROT_W-1:0]  s;
  logic signed [63:0]       prod;
  logic signed [63:0]       acc;
  logic signed [HOLD_W-1:0] hold;

  logic [1:0]               pi, pj, pik, pjk;
  logic signed [MAT_W-1:0]  aii, ajj, aij;
  logic [MAT_W-1:0]         aij_mag;
  logic signed [35:0]       x, y;
  logic                     big;
  logic [37:0]              discr;
  logic signed [39:0]       sum_p, sum_m, v1, v2;
  logic signed [34:0]       ma;
  logic signed [31:0]       mb;
  logic signed [63:0]       qs, qv, acc_rnd;
  logic [ROOT_W-1:0]        root;
  logic [31:0]              quot;
  logic                     sqrt_busy, div_busy;
  logic [DVD_W-1:0]         dividend;

  always_comb begin
    unique case (cmd.pair)
      PAIR_20: begin pi = 2'd2; pj = 2'd0; pik = 2'd2; pjk = 2'd0; end
      PAIR_21: begin pi = 2'd2; pj = 2'd1; pik = 2'd1; pjk = 2'd0; end
      default: begin pi = 2'd1; pj = 2'd0; pik = 2'd2; pjk = 2'd1; end
    endcase
  end

  assign aii     = d[pi];
  assign ajj     = d[pj];
  assign aij     = o[cmd.pair];
  assign aij_mag = MAT_W'(mag64(64'(aij)));
  assign x       = 36'(aii) - 36'(ajj);
  assign y       = 36'(aij) + 36'(aij);
  assign big     = |{red[0][RED_W-1:31], red[1][RED_W-1:31], red[2][RED_W-1:31]};
  assign discr   = 38'(root) << sh;
  assign sum_p   = 40'(aii) + 40'(ajj) + $signed({2'b00, discr});
  assign sum_m   = 40'(aii) + 40'(ajj) - $signed({2'b00, discr});
  assign v1      = (aii > ajj) ? 40'(x) + $signed({2'b00, discr}) : 40'(y);
  assign v2      = (aii > ajj) ? -40'(y) : 40'(x) - $signed({2'b00, discr});
  assign qs      = $signed({32'b0, quot});
  assign qv      = neg[cmd.sel] ? -qs : qs;
  assign acc_rnd = rnd64(acc, ROT_BITS);
  assign dividend = cmd.vec_mode ? {red[cmd.sel][30:0], 30'b0}
                                 : {2'b00, red[cmd.sel][30:0], 28'b0};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.msrc)
      MS_RED:   begin ma = 35'({4'b0, red[cmd.sel][30:0]});
                      mb = 32'({1'b0, red[cmd.sel][30:0]}); end
      MS_AIK_C: begin ma = 35'(o[pik]); mb = 32'(c); end
      MS_AJK_S: begin ma = 35'(o[pjk]); mb = 32'(s); end
      MS_AIK_S: begin ma = 35'(o[pik]); mb = 32'(s); end
      MS_AJK_C: begin ma = 35'(o[pjk]); mb = 32'(c); end
      MS_EJ_C:  begin ma = 35'(e[cmd.row][pj]); mb = 32'(c); end
      MS_EI_S:  begin ma = 35'(e[cmd.row][pi]); mb = 32'(s); end
      MS_EI_C:  begin ma = 35'(e[cmd.row][pi]); mb = 32'(c); end
      MS_EJ_S:  begin ma = 35'(e[cmd.row][pj]); mb = 32'(s); end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.msrc != MS_NONE) begin
      prod <= 64'(ma) * 64'(mb);
    end
    case (cmd.accm)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      ACC_SUB:  acc <= acc - prod;
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        d[0] <= MAT_W'(m00);
        d[1] <= MAT_W'(m11);
        d[2] <= MAT_W'(m22);
        o[0] <= MAT_W'(m01);
        o[1] <= MAT_W'(m02);
        o[2] <= MAT_W'(m12);
        for (int r = 0; r < MATRIX_DIM; r++) begin
          for (int k = 0; k < MATRIX_DIM; k++) begin
            e[r][k] <= (r == k) ? VEC_W'(64'd1 << VEC_BITS) : '0;
          end
        end
      end
      OP_HYP: begin
        red[0] <= RED_W'(mag64(64'(x)));
        red[1] <= RED_W'(mag64(64'(y)));
        red[2] <= '0;
        sh     <= '0;
      end
      OP_REDUCE: begin
        if (big) begin
          for (int k = 0; k < MATRIX_DIM; k++) begin
            red[k] <= red[k] >> 1;
          end
          sh <= sh + SH_W'(1);
        end
      end
      OP_DIAG: begin
        d[pi]       <= MAT_W'(sat64(rnd64(64'(sum_p), 1), MAT_LIM));
        d[pj]       <= MAT_W'(sat64(rnd64(64'(sum_m), 1), MAT_LIM));
        o[cmd.pair] <= '0;
        red[0]      <= RED_W'(mag64(64'(v1)));
        red[1]      <= RED_W'(mag64(64'(v2)));
        red[2]      <= '0;
        neg[0]      <= v1[39];
        neg[1]      <= v2[39];
        sh          <= '0;
      end
      OP_CS: begin
        if (cmd.sel == 2'd0) begin
          c <= (root == '0) ? ROT_W'(ROT_LIM) : ROT_W'(sat64(qv, ROT_LIM));
        end else begin
          s <= (root == '0) ? '0 : ROT_W'(sat64(qv, ROT_LIM));
        end
      end
      OP_HOLD: begin
        hold <= HOLD_W'(acc_rnd);
      end
      OP_WRA: begin
        o[pik] <= MAT_W'(sat64(64'(hold), MAT_LIM));
        o[pjk] <= MAT_W'(sat64(acc_rnd, MAT_LIM));
      end
      OP_WRE: begin
        e[cmd.row][pj] <= VEC_W'(sat64(64'(hold), VEC_LIM));
        e[cmd.row][pi] <= VEC_W'(sat64(acc_rnd, VEC_LIM));
      end
      OP_NORM: begin
        for (int r = 0; r < MATRIX_DIM; r++) begin
          red[r] <= RED_W'(mag64(64'(e[r][cmd.col])));
          neg[r] <= e[r][cmd.col][VEC_W-1];
        end
        sh <= '0;
      end
      OP_OUT: begin
        vout[cmd.col][cmd.sel] <= (root == '0) ? '0 : OUT_W'(sat64(qv, OUT_LIM));
      end
      default: begin end
    endcase
  end

  sym3eig_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQRT),
    .radicand ($unsigned(acc)),
    .busy     (sqrt_busy),
    .root     (root)
  );

  sym3eig_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV),
    .dividend (dividend),
    .divisor  (root),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign stat.above     = aij_mag > MAT_W'(thr);
  assign stat.red_ok    = !big;
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.div_busy  = div_busy;

endmodule

// File: hw/rtl/sym3eig_ctrl.sv
// ----------------------------------------------------------------------------
// sym3eig_ctrl
// Sequencer for sweeps, rotations and final normalization. Issues one
// datapath command per cycle; while the square root or divider is busy it issues NOP.
// ----------------------------------------------------------------------------
module sym3eig_ctrl import sym3eig_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SWP_W-1:0] max_sweeps,
  input  stat_t            stat,
  output cmd_t             cmd,
  output logic             busy,
  output logic             done,
  output logic             not_converged
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK     = 4'd1;
  localparam logic [3:0] S_RED     = 4'd2;
  localparam logic [3:0] S_SQ      = 4'd3;
  localparam logic [3:0] S_SQGO    = 4'd4;
  localparam logic [3:0] S_SQWAIT  = 4'd5;
  localparam logic [3:0] S_DIAG    = 4'd6;
  localparam logic [3:0] S_DIVGO   = 4'd7;
  localparam logic [3:0] S_DIVWAIT = 4'd8;
  localparam logic [3:0] S_AROT    = 4'd9;
  localparam logic [3:0] S_EROT    = 4'd10;
  localparam logic [3:0] S_NEXT    = 4'd11;
  localparam logic [3:0] S_NSET    = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  localparam logic [1:0] PH_HYP  = 2'd0;
  localparam logic [1:0] PH_UNIT = 2'd1;
  localparam logic [1:0] PH_NORM = 2'd2;

  logic [3:0]       state, state_next;
  logic [2:0]       step, step_next;
  logic [1:0]       pair, pair_next;
  logic [1:0]       row, row_next;
  logic [1:0]       col, col_next;
  logic [1:0]       idx, idx_next;
  logic [1:0]       phase, phase_next;
  logic [SWP_W-1:0] sw, sw_next;
  logic             rot, rot_next;
  logic             nc, nc_next;
  logic [SWP_W-1:0] limit;
  logic             erot;

  assign limit = (max_sweeps == '0) ? SWP_W'(1) : max_sweeps;
  assign erot  = (state == S_EROT);

  always_comb begin
    state_next = state;
    step_next  = step;
    pair_next  = pair;
    row_next   = row;
    col_next   = col;
    idx_next   = idx;
    phase_next = phase;
    sw_next    = sw;
    rot_next   = rot;
    nc_next    = nc;
    cmd          = '0;
    cmd.op       = OP_NOP;
    cmd.msrc     = MS_NONE;
    cmd.accm     = ACC_NONE;
    cmd.pair     = pair;
    cmd.row      = row;
    cmd.col      = col;
    cmd.sel      = idx;
    cmd.vec_mode = (phase == PH_NORM);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          pair_next  = PAIR_10;
          sw_next    = '0;
          rot_next   = 1'b0;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.above) begin
          cmd.op     = OP_HYP;
          phase_next = PH_HYP;
          state_next = S_RED;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_RED: begin
        cmd.op = OP_REDUCE;
        if (stat.red_ok) begin
          step_next  = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sel  = step[1:0];
        cmd.msrc = (step == 3'd3) ? MS_NONE : MS_RED;
        cmd.accm = (step == 3'd0) ? ACC_NONE : (step == 3'd1) ? ACC_LOAD : ACC_ADD;
        step_next = step + 3'd1;
        if (step == 3'd3) begin
          state_next = S_SQGO;
        end
      end
      S_SQGO: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (!stat.sqrt_busy) begin
          idx_next   = '0;
          state_next = (phase == PH_HYP) ? S_DIAG : S_DIVGO;
        end
      end
      S_DIAG: begin
        cmd.op     = OP_DIAG;
        phase_next = PH_UNIT;
        state_next = S_RED;
      end
      S_DIVGO: begin
        cmd.op     = OP_DIV;
        state_next = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!stat.div_busy) begin
          if (phase == PH_UNIT) begin
            cmd.op = OP_CS;
            if (idx == 2'd1) begin
              step_next  = '0;
              state_next = S_AROT;
            end else begin
              idx_next   = idx + 2'd1;
              state_next = S_DIVGO;
            end
          end else begin
            cmd.op = OP_OUT;
            if (idx == 2'd2) begin
              if (col == 2'd2) begin
                state_next = S_DONE;
              end else begin
                col_next   = col + 2'd1;
                state_next = S_NSET;
              end
            end else begin
              idx_next   = idx + 2'd1;
              state_next = S_DIVGO;
            end
          end
        end
      end
      S_AROT, S_EROT: begin
        step_next = step + 3'd1;
        case (step)
          3'd0: cmd.msrc = erot ? MS_EJ_C : MS_AIK_C;
          3'd1: begin
            cmd.msrc = erot ? MS_EI_S : MS_AJK_S;
            cmd.accm = ACC_LOAD;
          end
          3'd2: cmd.accm = erot ? ACC_ADD : ACC_SUB;
          3'd3: begin
            cmd.op   = OP_HOLD;
            cmd.msrc = erot ? MS_EI_C : MS_AIK_S;
          end
          3'd4: begin
            cmd.msrc = erot ? MS_EJ_S : MS_AJK_C;
            cmd.accm = ACC_LOAD;
          end
          3'd5: cmd.accm = erot ? ACC_SUB : ACC_ADD;
          default: begin
            cmd.op    = erot ? OP_WRE : OP_WRA;
            step_next = '0;
            if (!erot) begin
              row_next   = '0;
              state_next = S_EROT;
            end else if (row == 2'd2) begin
              rot_next   = 1'b1;
              state_next = S_NEXT;
            end else begin
              row_next = row + 2'd1;
            end
          end
        endcase
      end
      S_NEXT: begin
        if (pair == PAIR_21) begin
          if (!rot || (sw + SWP_W'(1)) == limit) begin
            nc_next    = rot;
            col_next   = '0;
            state_next = S_NSET;
          end else begin
            sw_next    = sw + SWP_W'(1);
            rot_next   = 1'b0;
            pair_next  = PAIR_10;
            state_next = S_CHK;
          end
        end else begin
          pair_next  = pair + 2'd1;
          state_next = S_CHK;
        end
      end
      S_NSET: begin
        cmd.op     = OP_NORM;
        phase_next = PH_NORM;
        state_next = S_RED;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nc    <= 1'b0;
    end else begin
      state <= state_next;
      nc    <= nc_next;
    end
    step  <= step_next;
    pair  <= pair_next;
    row   <= row_next;
    col   <= col_next;
    idx   <= idx_next;
    phase <= phase_next;
    sw    <= sw_next;
    rot   <= rot_next;
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign not_converged = nc;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after result transfer");

endmodule

// File: hw/rtl/symmetric_3x3_eigenvectors.sv
// ----------------------------------------------------------------------------
// symmetric_3x3_eigenvectors
// Eigenvectors of a symmetric 3x3 Q8.24 matrix by cyclic Jacobi rotation,
// returned as normalized Q2.30 column vectors.
//
//   channel   handshake                 payload
//   input     start / busy              m00 m11 m22 m01 m02 m12
//   result    done (one-cycle strobe)   vec1_* vec2_* vec3_* not_converged
//   config    APB psel/penable/pwrite   paddr pwdata prdata
//
// One matrix at a time. The time taken per rotation varies with operand
// reduction, and the run time is set by the iterative square root and
// divider. Synchronous reset returns the sequencer to idle and the registers to
// threshold 17, max_sweeps 16. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module symmetric_3x3_eigenvectors import sym3eig_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  m00,
  input  logic signed [IN_W-1:0]  m11,
  input  logic signed [IN_W-1:0]  m22,
  input  logic signed [IN_W-1:0]  m01,
  input  logic signed [IN_W-1:0]  m02,
  input  logic signed [IN_W-1:0]  m12,
  output logic                    done,
  output logic signed [OUT_W-1:0] vec1_x,
  output logic signed [OUT_W-1:0] vec1_y,
  output logic signed [OUT_W-1:0] vec1_z,
  output logic signed [OUT_W-1:0] vec2_x,
  output logic signed [OUT_W-1:0] vec2_y,
  output logic signed [OUT_W-1:0] vec2_z,
  output logic signed [OUT_W-1:0] vec3_x,
  output logic signed [OUT_W-1:0] vec3_y,
  output logic signed [OUT_W-1:0] vec3_z,
  output logic                    not_converged,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [THR_W-1:0]        thr;
  logic [SWP_W-1:0]        max_sweeps;
  cmd_t                    cmd;
  stat_t                   stat;
  logic signed [OUT_W-1:0] vout [MATRIX_DIM][MATRIX_DIM];

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(max_sweeps) : 32'(thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THR_RESET;
      max_sweeps <= SWP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        max_sweeps <= pwdata[SWP_W-1:0];
      end else begin
        thr <= pwdata[THR_W-1:0];
      end
    end
  end

  sym3eig_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .max_sweeps    (max_sweeps),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy),
    .done          (done),
    .not_converged (not_converged)
  );

  sym3eig_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .thr  (thr),
    .m00  (m00),
    .m11  (m11),
    .m22  (m22),
    .m01  (m01),
    .m02  (m02),
    .m12  (m12),
    .vout (vout)
  );

  assign vec1_x = vout[0][0];
  assign vec1_y = vout[0][1];
  assign vec1_z = vout[0][2];
  assign vec2_x = vout[1][0];
  assign vec2_y = vout[1][1];
  assign vec2_z = vout[1][2];
  assign vec3_x = vout[2][0];
  assign vec3_y = vout[2][1];
  assign vec3_z = vout[2][2];

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for symmetric_3x3_eigenvectors: a directed table and
// random matrices are sent through start/busy under several threshold and
// sweep-cap settings; each done strobe is checked against a Jacobi predictor.
// ----------------------------------------------------------------------------
module tb;
  import sym3eig_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam logic [2:0] ADDR_THR = 3'd0;
  localparam logic [2:0] ADDR_SWP = 3'd4;

  typedef struct {
    logic signed [31:0] v[9];
    logic               nc;
  } eig_t;

  typedef struct {
    logic signed [31:0] m[6];
    bit                 ident;
  } mat_row_t;

  logic clk = 0, rst = 1, start = 0;
  logic signed [31:0] m00 = 0, m11 = 0, m22 = 0, m01 = 0, m02 = 0, m12 = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic busy, done, not_converged, pready;
  logic [31:0] prdata;
  logic signed [31:0] vec1_x, vec1_y, vec1_z, vec2_x, vec2_y, vec2_z;
  logic signed [31:0] vec3_x, vec3_y, vec3_z;

  logic [15:0] thr_q = THR_RESET;
  logic [6:0]  swp_q = SWP_RESET;
  eig_t        pending_eig[$];
  int          errors = 0;
  longint      cycles = 0;

  symmetric_3x3_eigenvectors DUT (.*);

  always #5 clk = ~clk;

  function automatic longint clamp(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint round_sh(longint x, int sh);
    logic [63:0] half;
    half = 64'd1 << (sh - 1);
    if (x >= 0) return longint'((64'(x) + half) >> sh);
    return -longint'((64'(-x) + half) >> sh);
  endfunction

  function automatic logic [63:0] absv(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int shrink(ref logic [63:0] a[3], input int n);
    int sh;
    bit big;
    sh = 0;
    forever begin
      big = 0;
      for (int k = 0; k < n; k++) if (a[k] >= 64'h8000_0000) big = 1;
      if (!big) return sh;
      for (int k = 0; k < n; k++) a[k] >>= 1;
      sh++;
    end
  endfunction

  function automatic eig_t jacobi_eigvec(logic signed [31:0] m[6]);
    longint a[3][3], e[3][3];
    longint aii, ajj, aij, dis, v1, v2, c, s, aik, ajk, ej, ei, x;
    logic [63:0] w[3], n;
    int sh, lim;
    bit rot;
    eig_t res;
    lim = (swp_q == 0) ? 1 : swp_q;
    rot = 0;
    a[0][0] = m[0]; a[1][1] = m[1]; a[2][2] = m[2];
    a[0][1] = m[3]; a[1][0] = m[3];
    a[0][2] = m[4]; a[2][0] = m[4];
    a[1][2] = m[5]; a[2][1] = m[5];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) e[i][j] = (i == j) ? (64'sd1 << VEC_BITS) : 0;
    for (int sw = 0; sw < lim; sw++) begin
      rot = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < i; j++) begin
          aii = a[i][i]; ajj = a[j][j]; aij = a[i][j];
          if (absv(aij) <= 64'(thr_q)) continue;
          w[0] = absv(aii - ajj); w[1] = absv(2 * aij); w[2] = 0;
          sh = shrink(w, 2);
          dis = longint'(int_sqrt(w[0] * w[0] + w[1] * w[1]) << sh);
          a[i][i] = clamp(round_sh(aii + ajj + dis, 1), MAT_LIM);
          a[j][j] = clamp(round_sh(aii + ajj - dis, 1), MAT_LIM);
          a[i][j] = 0; a[j][i] = 0;
          if (aii > ajj) begin
            v1 = aii - ajj + dis; v2 = -2 * aij;
          end else begin
            v1 = 2 * aij; v2 = -(ajj - aii + dis);
          end
          w[0] = absv(v1); w[1] = absv(v2); w[2] = 0;
          void'(shrink(w, 2));
          n = int_sqrt(w[0] * w[0] + w[1] * w[1]);
          if (n == 0) begin
            c = ROT_LIM; s = 0;
          end else begin
            c = longint'((w[0] << ROT_BITS) / n);
            s = longint'((w[1] << ROT_BITS) / n);
            c = clamp(v1 < 0 ? -c : c, ROT_LIM);
            s = clamp(v2 < 0 ? -s : s, ROT_LIM);
          end
          for (int k = 0; k < 3; k++) begin
            if (k == i || k == j) continue;
            aik = a[i][k]; ajk = a[j][k];
            a[i][k] = clamp(round_sh(aik * c - ajk * s, ROT_BITS), MAT_LIM);
            a[k][i] = a[i][k];
            a[j][k] = clamp(round_sh(aik * s + ajk * c, ROT_BITS), MAT_LIM);
            a[k][j] = a[j][k];
          end
          for (int r = 0; r < 3; r++) begin
            ej = e[r][j]; ei = e[r][i];
            e[r][j] = clamp(round_sh(ej * c + ei * s, ROT_BITS), VEC_LIM);
            e[r][i] = clamp(round_sh(ei * c - ej * s, ROT_BITS), VEC_LIM);
          end
          rot = 1;
        end
      if (!rot) break;
    end
    for (int j = 0; j < 3; j++) begin
      for (int r = 0; r < 3; r++) w[r] = absv(e[r][j]);
      void'(shrink(w, 3));
      n = int_sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
      for (int r = 0; r < 3; r++) begin
        x = 0;
        if (n != 0) begin
          x = longint'((w[r] << VEC_BITS) / n);
          if (e[r][j] < 0) x = -x;
          x = clamp(x, OUT_LIM);
        end
        res.v[j * 3 + r] = x[31:0];
      end
    end
    res.nc = rot;
    return res;
  endfunction

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_THR) thr_q = data[15:0];
    else swp_q = data[6:0];
    @(posedge clk);
  endtask

  // hold off until every transfer is back, then retune the engine
  task automatic reconfigure(logic [15:0] thr, logic [6:0] swp);
    start <= 0;
    @(posedge clk);
    while (pending_eig.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    apb_write(ADDR_THR, {16'd0, thr});
    apb_write(ADDR_SWP, {25'd0, swp});
  endtask

  task automatic send_matrix(mat_row_t row, int gap);
    eig_t exp_eig;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    m00 <= row.m[0]; m11 <= row.m[1]; m22 <= row.m[2];
    m01 <= row.m[3]; m02 <= row.m[4]; m12 <= row.m[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_eig = jacobi_eigvec(row.m);
    if (row.ident) begin
      foreach (exp_eig.v[k]) exp_eig.v[k] = (k % 4 == 0) ? 32'sh4000_0000 : 32'sh0;
      exp_eig.nc = 0;
    end
    pending_eig.push_back(exp_eig);
  endtask

  function automatic mat_row_t rand_matrix();
    mat_row_t row;
    int sh;
    sh = $urandom_range(0, 31);
    for (int k = 0; k < 6; k++)
      row.m[k] = ($urandom_range(0, 3) == 0) ? 32'sh0 : $signed($urandom) >>> sh;
    if ($urandom_range(0, 7) == 0) row.m[$urandom_range(3, 5)] = 0;
    row.ident = 0;
    return row;
  endfunction

  task automatic random_burst(int count);
    repeat (count) send_matrix(rand_matrix(), $urandom_range(0, 3) == 0 ? 0 :
                               $urandom_range(0, 18));
  endtask

  always @(posedge clk) begin
    logic signed [31:0] got[9];
    eig_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && done) begin
      got = '{vec1_x, vec1_y, vec1_z, vec2_x, vec2_y, vec2_z, vec3_x, vec3_y, vec3_z};
      if (pending_eig.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
      end else begin
        want = pending_eig.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want.v[k]) begin
            $display("%0t: vec%0d[%0d] expected %0d actual %0d", $time, k / 3 + 1,
                     k % 3, want.v[k], got[k]);
            errors++;
          end
        if (not_converged !== want.nc) begin
          $display("%0t: not_converged expected %0b actual %0b", $time, want.nc,
                   not_converged);
          errors++;
        end
      end
    end
  end

  initial begin
    mat_row_t table_rows[$];
    mat_row_t row;
    logic signed [31:0] mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    table_rows = '{
      '{'{0, 0, 0, 0, 0, 0}, 1},
      '{'{mx, mx, mx, 0, 0, 0}, 1},
      '{'{mn, mn, mn, 0, 0, 0}, 1},
      '{'{mx, mn, 5, 17, -17, 3}, 1},
      '{'{0, 0, 0, 18, 0, 0}, 0},
      '{'{0, 0, 0, 0, -18, 0}, 0},
      '{'{0, 0, 0, 0, 0, 18}, 0},
      '{'{mx, mx, mx, mx, mx, mx}, 0},
      '{'{mn, mn, mn, mn, mn, mn}, 0},
      '{'{mx, mn, mx, mn, mx, mn}, 0},
      '{'{mn, mx, 0, mx, mn, mx}, 0},
      '{'{32'sh0100_0000, 32'sh0200_0000, 32'sh0300_0000, 32'sh0080_0000,
          32'sh0040_0000, -32'sh0020_0000}, 0},
      '{'{5, 5, 5, 32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000}, 0},
      '{'{-1, -1, -1, -1, -1, -1}, 0},
      '{'{32'sh5555_5555, 32'shaaaa_aaaa, 0, 32'sh5555_5555, 32'shaaaa_aaaa,
          32'sh1234_5678}, 0}
    };
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (table_rows[k]) send_matrix(table_rows[k], k % 3 == 0 ? 0 : $urandom_range(0, 18));
    random_burst(300);

    reconfigure(16'd0, 7'd1);
    foreach (table_rows[k]) begin
      row = table_rows[k];
      row.ident = 0;
      send_matrix(row, $urandom_range(0, 18));
    end
    random_burst(200);

    reconfigure(16'hffff, 7'd64);
    random_burst(30);

    reconfigure(16'd0, 7'd2);
    random_burst(150);

    reconfigure(16'h0040, 7'd0);
    random_burst(100);

    reconfigure(16'h1000, 7'd3);
    random_burst(100);

    reconfigure(16'd0, 7'd64);
    random_burst(30);

    reconfigure(THR_RESET, SWP_RESET);
    random_burst(100);

    start <= 0;
    while (pending_eig.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/sym3eig_pkg.sv
hw/rtl/sym3eig_sqrt.sv
hw/rtl/sym3eig_div.sv
hw/rtl/sym3eig_dp.sv
hw/rtl/sym3eig_ctrl.sv
hw/rtl/symmetric_3x3_eigenvectors.sv
dv/tb.sv
